// ===== rtl/core/ctb_pkg.sv =====
// ctb_pkg: shared sizes, opcodes and state types of the cursor text buffer
// depends on nothing; imported by cursor_text_buffer
package ctb_pkg;

    // line capacity in characters (2 .. 63)
    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam int CHAR_W   = 8;
    localparam int MOVE_W   = 8;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TYPE  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_BACK  = 2'd2,
        OP_PRINT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE_R,
        ST_MOVE_L,
        ST_PRINT
    } state_t;

    // where the item in the read stage comes from
    typedef enum logic [1:0] {
        SRC_LEFT,
        SRC_RIGHT,
        SRC_EOL
    } src_t;

endpackage

// ===== rtl/core/cursor_text_buffer.sv =====
// cursor_text_buffer: gap buffer line editor with two character stacks in ram
// depends on ctb_pkg (sizes, opcodes, state types)
//
//  channel | ports                     | contents
//  --------+---------------------------+----------------------------------------
//  input   | s_tvalid s_tready s_tdata | tuser: opcode; tdata: char_in, move_amount
//          | s_tuser                   |
//  output  | m_tvalid m_tready m_tdata | tdata: char_out; tuser: end_of_line;
//          | m_tuser m_tlast           | tlast: last
//
// type and backspace complete on acceptance, leaving the input ready for the next
// command. move carries one character a cycle through a read of one stack ram and a
// write of the other. print issues one stack ram read a cycle while the sink keeps
// up, left+right+1 transfers in all; a stalled sink holds the reads back and a
// 2-entry output queue takes up the slack.
// reset (aresetn low, synchronous) clears counts, sequencer and queue; ram
// contents stay undefined until written, and only entries below a count are read.
module cursor_text_buffer
    import ctb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [7:0] char_in, [15:8] move_amount
    input  logic [OP_W-1:0]   s_tuser,   // [1:0] opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] char_out
    output logic              m_tuser,   // [0] end_of_line
    output logic              m_tlast
);

    // stack rams
    logic [CHAR_W-1:0] left_mem  [CAPACITY];
    logic [CHAR_W-1:0] right_mem [CAPACITY];
    logic [CHAR_W-1:0] left_rd_reg, right_rd_reg;
    logic [ADDR_W-1:0] left_raddr, right_raddr, left_waddr;
    logic              left_we, right_we;
    logic [CHAR_W-1:0] left_wdata;

    // control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  lc_reg, lc_next, rc_reg, rc_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [MOVE_W-1:0] dist_reg, dist_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [ADDR_W-1:0] wdst_reg, wdst_next;
    logic              stage_vld_reg, stage_vld_next;
    src_t              stage_src_reg, stage_src_next;

    // output queue
    logic [CHAR_W-1:0] q_char_reg [2];
    logic              q_eol_reg  [2];
    logic              q_wptr_reg, q_rptr_reg;
    logic [1:0]        q_cnt_reg;

    logic              in_xfer, out_xfer, can_issue;
    logic [2:0]        occ;
    logic [CNT_W:0]    total, right_pos;
    op_t               op;
    logic [CHAR_W-1:0] char_in;
    logic [MOVE_W-1:0] move_amount;
    logic [CHAR_W-1:0] push_char;

    assign op          = op_t'(s_tuser);
    assign char_in     = s_tdata[7:0];
    assign move_amount = s_tdata[15:8];
    assign s_tready    = (state_reg == ST_IDLE) && !wr_pend_reg;
    assign in_xfer     = s_tvalid && s_tready;
    assign out_xfer    = m_tvalid && m_tready;

    // items held or on their way to the queue decide whether a read may issue
    assign occ       = {1'b0, q_cnt_reg} + {2'b00, stage_vld_reg};
    assign can_issue = (occ < 3'd2) || ((occ == 3'd2) && out_xfer);

    assign total     = {1'b0, lc_reg} + {1'b0, rc_reg};
    assign right_pos = total - {{CNT_W{1'b0}}, 1'b1} - {1'b0, pos_reg};

    // sequencer: next state, counts and ram addresses
    always_comb begin
        state_next     = state_reg;
        lc_next        = lc_reg;
        rc_next        = rc_reg;
        pos_next       = pos_reg;
        dist_next      = dist_reg;
        wr_pend_next   = 1'b0;
        wdst_next      = wdst_reg;
        stage_vld_next = 1'b0;
        stage_src_next = stage_src_reg;
        left_raddr     = pos_reg[ADDR_W-1:0];
        right_raddr    = right_pos[ADDR_W-1:0];
        left_we        = 1'b0;
        left_waddr     = wdst_reg;
        left_wdata     = right_rd_reg;
        right_we       = 1'b0;

        // finish the write half of a move step issued last cycle
        if (wr_pend_reg) begin
            if (state_reg == ST_MOVE_L) begin
                right_we = 1'b1;
            end else begin
                left_we = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    case (op)
                        OP_TYPE: begin
                            if (total < (CNT_W+1)'(CAPACITY)) begin
                                left_we    = 1'b1;
                                left_waddr = lc_reg[ADDR_W-1:0];
                                left_wdata = char_in;
                                lc_next    = lc_reg + 1'b1;
                            end
                        end
                        OP_MOVE: begin
                            if (move_amount[MOVE_W-1]) begin
                                dist_next  = MOVE_W'(0) - move_amount;
                                state_next = ST_MOVE_L;
                            end else if (move_amount != '0) begin
                                dist_next  = move_amount;
                                state_next = ST_MOVE_R;
                            end
                        end
                        OP_BACK: begin
                            if (lc_reg != '0) begin
                                lc_next = lc_reg - 1'b1;
                            end
                        end
                        OP_PRINT: begin
                            pos_next   = '0;
                            state_next = ST_PRINT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MOVE_R: begin
                // pop right stack top, push onto left stack next cycle
                right_raddr = rc_reg[ADDR_W-1:0] - 1'b1;
                if (dist_reg != '0 && rc_reg != '0 && lc_reg < CNT_W'(CAPACITY)) begin
                    rc_next      = rc_reg - 1'b1;
                    lc_next      = lc_reg + 1'b1;
                    wdst_next    = lc_reg[ADDR_W-1:0];
                    wr_pend_next = 1'b1;
                    dist_next    = dist_reg - 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE_L: begin
                // pop left stack top, push onto right stack next cycle
                left_raddr = lc_reg[ADDR_W-1:0] - 1'b1;
                if (dist_reg != '0 && lc_reg != '0 && rc_reg < CNT_W'(CAPACITY)) begin
                    lc_next      = lc_reg - 1'b1;
                    rc_next      = rc_reg + 1'b1;
                    wdst_next    = rc_reg[ADDR_W-1:0];
                    wr_pend_next = 1'b1;
                    dist_next    = dist_reg - 1'b1;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PRINT: begin
                // one character a cycle while the output queue has room: left stack bottom up, right stack top down
                if (can_issue) begin
                    stage_vld_next = 1'b1;
                    pos_next       = pos_reg + 1'b1;
                    if ({1'b0, pos_reg} < {1'b0, lc_reg}) begin
                        stage_src_next = SRC_LEFT;
                    end else if ({1'b0, pos_reg} < total) begin
                        stage_src_next = SRC_RIGHT;
                    end else begin
                        stage_src_next = SRC_EOL;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lc_reg        <= '0;
            rc_reg        <= '0;
            wr_pend_reg   <= 1'b0;
            stage_vld_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lc_reg        <= lc_next;
            rc_reg        <= rc_next;
            wr_pend_reg   <= wr_pend_next;
            stage_vld_reg <= stage_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        dist_reg      <= dist_next;
        wdst_reg      <= wdst_next;
        stage_src_reg <= stage_src_next;
    end

    // left stack ram
    always_ff @(posedge aclk) begin
        if (left_we) begin
            left_mem[left_waddr] <= left_wdata;
        end
        left_rd_reg <= left_mem[left_raddr];
    end

    // right stack ram
    always_ff @(posedge aclk) begin
        if (right_we) begin
            right_mem[wdst_reg] <= left_rd_reg;
        end
        right_rd_reg <= right_mem[right_raddr];
    end

    // read stage data into the output queue
    always_comb begin
        case (stage_src_reg)
            SRC_LEFT:  push_char = left_rd_reg;
            SRC_RIGHT: push_char = right_rd_reg;
            default:   push_char = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_vld_reg) begin
            q_char_reg[q_wptr_reg] <= push_char;
            q_eol_reg[q_wptr_reg]  <= (stage_src_reg == SRC_EOL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wptr_reg <= 1'b0;
            q_rptr_reg <= 1'b0;
            q_cnt_reg  <= '0;
        end else begin
            if (stage_vld_reg) begin
                q_wptr_reg <= ~q_wptr_reg;
            end
            if (out_xfer) begin
                q_rptr_reg <= ~q_rptr_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, stage_vld_reg} - {1'b0, out_xfer};
        end
    end

    // result channel
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = q_char_reg[q_rptr_reg];
    assign m_tuser  = q_eol_reg[q_rptr_reg];
    assign m_tlast  = q_eol_reg[q_rptr_reg];

endmodule

// ===== verif/tb_cursor_text_buffer.sv =====
`timescale 1ns / 100ps
// tb_cursor_text_buffer: self-checking stream testbench for the gap buffer line editor
// depends on ctb_pkg and cursor_text_buffer; tracks the line in its own two stacks
// and checks every printed character and end-of-line transfer in order
module tb_cursor_text_buffer;
    import ctb_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_TICKS = 40;
    localparam int PHASE_EDITS  = 65;

    // one edit command as it travels on the input channel
    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [MOVE_W-1:0] amount;
    } edit_t;

    // one printed transfer
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eol;
        logic              fin;
    } line_out_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata  = '0;
    logic [OP_W-1:0]   s_tuser  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    // line model: chars left of the cursor bottom-up, chars right of it top at right_len-1
    logic [CHAR_W-1:0] left_side  [CAPACITY];
    logic [CHAR_W-1:0] right_side [CAPACITY];
    logic [CNT_W-1:0]  left_len  = '0;
    logic [CNT_W-1:0]  right_len = '0;

    edit_t     pending_edits [$];
    line_out_t printed_line  [$];
    edit_t     on_bus;
    edit_t     next_edit;
    line_out_t oldest;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;

    cursor_text_buffer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // apply one accepted edit to the line model and queue what a print shows
    task automatic apply_edit(edit_t e);
        int steps;
        case (e.op)
            OP_TYPE: begin
                // full line drops the character
                if (left_len + right_len < CAPACITY) begin
                    left_side[left_len] = e.ch;
                    left_len++;
                end
            end
            OP_MOVE: begin
                steps = $signed(e.amount);
                // clamp at either end of the line
                while (steps > 0 && right_len > 0) begin
                    right_len--;
                    left_side[left_len] = right_side[right_len];
                    left_len++;
                    steps--;
                end
                while (steps < 0 && left_len > 0) begin
                    left_len--;
                    right_side[right_len] = left_side[left_len];
                    right_len++;
                    steps++;
                end
            end
            OP_BACK: begin
                if (left_len > 0)
                    left_len--;
            end
            default: begin
                for (int i = 0; i < left_len; i++)
                    printed_line.push_back(line_out_t'{left_side[i], 1'b0, 1'b0});
                for (int i = right_len; i > 0; i--)
                    printed_line.push_back(line_out_t'{right_side[i-1], 1'b0, 1'b0});
                printed_line.push_back(line_out_t'{8'h00, 1'b1, 1'b1});
            end
        endcase
    endtask

    task automatic push_edit(op_t op, logic [CHAR_W-1:0] ch, logic [MOVE_W-1:0] amount);
        pending_edits.push_back(edit_t'{op, ch, amount});
    endtask

    // random edit, print about one in ten; moves are short (up to 8) half the time, else any byte
    function automatic edit_t rand_edit(int type_pct);
        edit_t e;
        int    r;
        int    d;
        r = $urandom_range(99);
        if (r < type_pct)
            e.op = OP_TYPE;
        else if (r < type_pct + (90 - type_pct) / 2)
            e.op = OP_MOVE;
        else if (r < 90)
            e.op = OP_BACK;
        else
            e.op = OP_PRINT;
        e.ch = CHAR_W'($urandom_range(255));
        if ($urandom_range(1)) begin
            d = $urandom_range(8);
            e.amount = $urandom_range(1) ? MOVE_W'(-d) : MOVE_W'(d);
        end else begin
            e.amount = MOVE_W'($urandom_range(255));
        end
        return e;
    endfunction

    // fill the line past capacity, print it, then trim from the end
    task automatic fill_burst(ref int added);
        int trims;
        trims = $urandom_range(30, 8);
        repeat (CAPACITY + 2)
            push_edit(OP_TYPE, CHAR_W'($urandom_range(255)), MOVE_W'($urandom_range(255)));
        push_edit(OP_PRINT, CHAR_W'($urandom_range(255)), MOVE_W'($urandom_range(255)));
        push_edit(OP_MOVE, CHAR_W'($urandom_range(255)), 8'h7f);
        repeat (trims)
            push_edit(OP_BACK, CHAR_W'($urandom_range(255)), MOVE_W'($urandom_range(255)));
        added += CAPACITY + 4 + trims;
    endtask

    task automatic add_random(int count);
        int added;
        int type_pct;
        added = 0;
        fill_burst(added);
        while (added < count) begin
            if ($urandom_range(15) == 0) begin
                fill_burst(added);
            end else begin
                type_pct = $urandom_range(1) ? 45 : 25;
                pending_edits.push_back(rand_edit(type_pct));
                added++;
            end
        end
    endtask

    // hold further stimulus until every edit is taken and every print has come back
    task automatic drain();
        while (pending_edits.size() != 0 || s_tvalid || printed_line.size() != 0)
            @(negedge aclk);
    endtask

    // driver: predict on each accepted transfer, then offer the next edit
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                apply_edit(on_bus);
            if (!s_tvalid || s_tready) begin
                if (pending_edits.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_edit = pending_edits.pop_front();
                    on_bus    = next_edit;
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_edit.op;
                    s_tdata  <= {next_edit.amount, next_edit.ch};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink ready
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (printed_line.size() == 0) begin
                    $display("%0t: unexpected transfer char_out %02h eol %0b last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatches++;
                end else begin
                    oldest = printed_line.pop_front();
                    if (m_tdata !== oldest.ch) begin
                        $display("%0t: char_out expected %02h actual %02h",
                                 $time, oldest.ch, m_tdata);
                        mismatches++;
                    end
                    if (m_tuser !== oldest.eol) begin
                        $display("%0t: end_of_line expected %0b actual %0b",
                                 $time, oldest.eol, m_tuser);
                        mismatches++;
                    end
                    if (m_tlast !== oldest.fin) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, oldest.fin, m_tlast);
                        mismatches++;
                    end
                end
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty line, start and end clamps, zero move, byte extremes
        push_edit(OP_PRINT, 8'hff, 8'hff);
        push_edit(OP_BACK,  8'h00, 8'h00);
        push_edit(OP_MOVE,  8'h00, 8'h80);
        push_edit(OP_MOVE,  8'hff, 8'h7f);
        push_edit(OP_TYPE,  8'h00, 8'hff);
        push_edit(OP_TYPE,  8'hff, 8'h00);
        push_edit(OP_TYPE,  8'ha5, 8'h5a);
        push_edit(OP_TYPE,  8'h5a, 8'ha5);
        push_edit(OP_MOVE,  8'h33, 8'h00);
        push_edit(OP_MOVE,  8'h00, 8'hfe);
        push_edit(OP_PRINT, 8'h00, 8'h00);
        push_edit(OP_TYPE,  8'h41, 8'h01);
        push_edit(OP_MOVE,  8'h00, 8'h80);
        push_edit(OP_BACK,  8'h00, 8'h00);
        push_edit(OP_TYPE,  8'h42, 8'h00);
        push_edit(OP_PRINT, 8'h00, 8'h00);
        push_edit(OP_MOVE,  8'h00, 8'h7f);
        push_edit(OP_MOVE,  8'h00, 8'h01);
        push_edit(OP_BACK,  8'h00, 8'h00);
        push_edit(OP_MOVE,  8'h00, 8'hff);
        push_edit(OP_PRINT, 8'h00, 8'h00);
        drain();

        // random phases: free running, slow sender, slow sink, both
        add_random(PHASE_EDITS);
        drain();
        send_idle_pct = 87;
        add_random(PHASE_EDITS);
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 87;
        add_random(PHASE_EDITS);
        drain();
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        add_random(PHASE_EDITS);
        drain();

        repeat (SETTLE_TICKS) @(posedge aclk);
        if (mismatches == 0 && printed_line.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/ctb_pkg.sv
rtl/core/cursor_text_buffer.sv
verif/tb_cursor_text_buffer.sv
